// ===== rtl/mqsb_pkg.sv =====
// Shared types, operation codes and status codes for the multi-queue shared buffer.
package mqsb_pkg;

  typedef logic [1:0]         op_t;
  typedef logic [1:0]         qid_t;
  typedef logic signed [31:0] word_t;
  typedef logic [1:0]         status_t;

  // Request operations
  localparam op_t OP_PUSH = 2'd0;
  localparam op_t OP_POP  = 2'd1;
  localparam op_t OP_READ = 2'd2;

  // Result status codes
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_OVERFLOW  = 2'd1;
  localparam status_t ST_UNDERFLOW = 2'd2;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic    capture;        // latch the accepted request, launch pointer reads
    logic    push_a;         // take free slot, write data/tail/head, chain old tail
    logic    push_b;         // terminate the new slot's link
    logic    pop_a;          // read the head slot's link
    logic    pop_b;          // advance head, return slot to free list
    logic    res_load;       // load the working result
    status_t res_status;
    logic    res_take_data;  // result value comes from the data store
    logic    out_load;       // move working result into the output register
  } mqsb_cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    op_t  op;
    logic qok;      // queue number is in range
    logic empty;    // addressed queue holds nothing
    logic no_free;  // free list is exhausted
  } mqsb_stat_t;

endpackage

// ===== rtl/mqsb_if.sv =====
// Request and response channel interfaces with valid/ready handshake.
interface mqsb_req_if import mqsb_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   op;
  qid_t  queue_id;
  word_t push_value;

  modport source (output valid, output op, output queue_id, output push_value, input ready);
  modport sink   (input valid, input op, input queue_id, input push_value, output ready);
endinterface

interface mqsb_rsp_if import mqsb_pkg::*; ();
  logic    valid;
  logic    ready;
  word_t   head_value;
  status_t status;

  modport source (output valid, output head_value, output status, input ready);
  modport sink   (input valid, input head_value, input status, output ready);
endinterface

// ===== rtl/multi_queue_shared_buffer.sv =====
// Top level: several FIFO queues sharing one slot buffer with a free list.
// Up to NUM_QUEUES FIFO queues share BUFFER_SLOTS data slots; each slot carries
// a link, and unused slots form a free stack. A request word pushes a value onto
// a queue, pops a queue's head, or reads a queue's head value, and yields exactly
// one response word with a status (ok, overflow, underflow) and the head value on
// a read. Requests are served one at a time: a push, pop or read passes lookup,
// an update or data state and result handoff, with two chained registered store
// reads (queue head pointer, then the slot's link or data); a rejected or ignored
// request skips the update. The response sits in an output register, so the next
// request is taken while a response still waits. No clearing pass follows reset.
module multi_queue_shared_buffer import mqsb_pkg::*; #(
  parameter int NUM_QUEUES   = 4,
  parameter int BUFFER_SLOTS = 16
) (
  input logic         clk,
  input logic         rst,
  mqsb_req_if.sink    req,
  mqsb_rsp_if.source  rsp
);
  mqsb_cmd_t  cmd;
  mqsb_stat_t stat;

  mqsb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  mqsb_dp #(.NUM_QUEUES(NUM_QUEUES), .BUFFER_SLOTS(BUFFER_SLOTS)) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .op         (req.op),
    .queue_id   (req.queue_id),
    .push_value (req.push_value),
    .head_value (rsp.head_value),
    .status     (rsp.status)
  );

  // One request in flight: ready drops right after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while another is in progress");

  // Only defined status codes leave the block
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (rsp.status == ST_OK || rsp.status == ST_OVERFLOW ||
                   rsp.status == ST_UNDERFLOW))
    else $error("undefined status code on response");

  // Failed requests return a zero value
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.head_value == '0)
    else $error("nonzero head value on failed request");

  // A response is loaded only from the result stage, never during accept
  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !req.ready)
    else $error("response loaded while idle");
endmodule

// ===== rtl/mqsb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module mqsb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [AW-1:0]        raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/mqsb_dp.sv =====
// Datapath: pointer, link and data stores, free list head and result registers.
module mqsb_dp import mqsb_pkg::*; #(
  parameter int NUM_QUEUES   = 4,
  parameter int BUFFER_SLOTS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  mqsb_cmd_t  cmd,
  output mqsb_stat_t stat,
  input  op_t        op,
  input  qid_t       queue_id,
  input  word_t      push_value,
  output word_t      head_value,
  output status_t    status
);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW = $clog2(BUFFER_SLOTS);
  localparam int LW = $clog2(BUFFER_SLOTS + 1);
  localparam logic [LW-1:0] SLOT_NONE = LW'(BUFFER_SLOTS);

  // Latched request
  op_t           req_op;
  logic          req_qok;
  logic [QW-1:0] req_qidx;
  word_t         req_value;

  // Free list: stack head plus count of slots whose link was ever written
  logic [LW-1:0] free_head, free_head_next;
  logic [LW-1:0] fill, fill_next;
  logic [NUM_QUEUES-1:0] nonempty;
  logic [SW-1:0] slot;

  word_t   res_value;
  status_t res_status;

  // Store ports
  logic [SW-1:0] head_rdata, tail_rdata;
  logic [LW-1:0] link_rdata;
  word_t         data_rdata;
  logic          head_we, link_we;
  logic [SW-1:0] head_wdata, link_waddr, link_raddr;
  logic [LW-1:0] link_wdata;
  logic          nx_ok;
  logic          cur_empty;

  assign cur_empty = !nonempty[req_qidx];
  assign nx_ok     = link_rdata < SLOT_NONE;

  assign stat.op      = req_op;
  assign stat.qok     = req_qok;
  assign stat.empty   = cur_empty;
  assign stat.no_free = (free_head == SLOT_NONE);

  // Next free slot: never-linked slots chain to their successor
  always_comb begin
    free_head_next = free_head;
    fill_next      = fill;
    if (cmd.push_a) begin
      if (free_head == fill) begin
        free_head_next = free_head + LW'(1);
        fill_next      = fill + LW'(1);
      end else begin
        free_head_next = link_rdata;
      end
    end else if (cmd.pop_b) begin
      free_head_next = LW'(slot);
    end
  end

  // Control state of the free list and queue occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head <= '0;
      fill      <= '0;
      nonempty  <= '0;
    end else begin
      free_head <= free_head_next;
      fill      <= fill_next;
      if (cmd.push_a) begin
        nonempty[req_qidx] <= 1'b1;
      end else if (cmd.pop_b && !nx_ok) begin
        nonempty[req_qidx] <= 1'b0;
      end
    end
  end

  // Request, slot and result registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_op    <= op;
      req_qok   <= 32'(queue_id) < NUM_QUEUES;
      req_qidx  <= QW'(queue_id);
      req_value <= push_value;
    end
    if (cmd.push_a) begin
      slot <= free_head[SW-1:0];
    end else if (cmd.pop_a) begin
      slot <= head_rdata;
    end
    if (cmd.res_load) begin
      res_status <= cmd.res_status;
      res_value  <= cmd.res_take_data ? data_rdata : '0;
    end
    if (cmd.out_load) begin
      head_value <= res_value;
      status     <= res_status;
    end
  end

  // Head pointer writes: first push into an empty queue, or pop advance
  assign head_we    = (cmd.push_a && cur_empty) || (cmd.pop_b && nx_ok);
  assign head_wdata = cmd.push_a ? free_head[SW-1:0] : link_rdata[SW-1:0];

  // Link writes: chain old tail, terminate new slot, or push freed slot
  assign link_we    = (cmd.push_a && !cur_empty) || cmd.push_b || cmd.pop_b;
  assign link_waddr = cmd.push_a ? tail_rdata : slot;
  assign link_wdata = cmd.push_b ? SLOT_NONE : free_head;
  assign link_raddr = cmd.pop_a ? head_rdata : free_head[SW-1:0];

  mqsb_ram #(.WIDTH(SW), .DEPTH(NUM_QUEUES)) u_head (
    .clk   (clk),
    .we    (head_we),
    .waddr (req_qidx),
    .wdata (head_wdata),
    .raddr (QW'(queue_id)),
    .rdata (head_rdata)
  );

  mqsb_ram #(.WIDTH(SW), .DEPTH(NUM_QUEUES)) u_tail (
    .clk   (clk),
    .we    (cmd.push_a),
    .waddr (req_qidx),
    .wdata (free_head[SW-1:0]),
    .raddr (QW'(queue_id)),
    .rdata (tail_rdata)
  );

  mqsb_ram #(.WIDTH(LW), .DEPTH(BUFFER_SLOTS)) u_link (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  mqsb_ram #(.WIDTH(32), .DEPTH(BUFFER_SLOTS)) u_data (
    .clk   (clk),
    .we    (cmd.push_a),
    .waddr (free_head[SW-1:0]),
    .wdata (req_value),
    .raddr (head_rdata),
    .rdata (data_rdata)
  );
endmodule

// ===== rtl/mqsb_ctrl.sv =====
// Sequencer: steps each request through pointer lookup, update and result handoff.
module mqsb_ctrl import mqsb_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  input  mqsb_stat_t stat,
  output mqsb_cmd_t  cmd
);
  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOOK  = 6'b000010,
    S_PUSH2 = 6'b000100,
    S_POP2  = 6'b001000,
    S_READ2 = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   op_known;

  assign req_ready = (state == S_IDLE);
  assign op_known  = (stat.op == OP_PUSH) || (stat.op == OP_POP) || (stat.op == OP_READ);

  // Decode state into datapath commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.capture = req_valid;
        if (req_valid) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK: begin
        priority if (!stat.qok || !op_known) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OK;
          state_next     = S_DONE;
        end else if (stat.op == OP_PUSH && stat.no_free) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_OVERFLOW;
          state_next     = S_DONE;
        end else if (stat.op != OP_PUSH && stat.empty) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ST_UNDERFLOW;
          state_next     = S_DONE;
        end else if (stat.op == OP_PUSH) begin
          cmd.push_a = 1'b1;
          state_next = S_PUSH2;
        end else if (stat.op == OP_POP) begin
          cmd.pop_a  = 1'b1;
          state_next = S_POP2;
        end else begin
          state_next = S_READ2;
        end
      end
      S_PUSH2: begin
        cmd.push_b     = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_DONE;
      end
      S_POP2: begin
        cmd.pop_b      = 1'b1;
        cmd.res_load   = 1'b1;
        cmd.res_status = ST_OK;
        state_next     = S_DONE;
      end
      S_READ2: begin
        cmd.res_load      = 1'b1;
        cmd.res_status    = ST_OK;
        cmd.res_take_data = 1'b1;
        state_next        = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state, hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end
endmodule

// ===== tb/multi_queue_shared_buffer_test.sv =====
// Testbench for the multi-queue shared buffer: directed table plus predicted random traffic.
`timescale 1ns / 100ps

module multi_queue_shared_buffer_test;
  import mqsb_pkg::*;

  localparam int NUM_QUEUES   = 4;
  localparam int BUFFER_SLOTS = 16;
  localparam logic [4:0] SLOT_NONE = 5'(BUFFER_SLOTS);
  localparam op_t OP_UNUSED = 2'd3;
  localparam int LONG_HOLD_CYCLES = 300;

  // One request word, with an optional hand-written expectation
  typedef struct packed {
    op_t     op;
    qid_t    queue_id;
    word_t   push_value;
    logic    typed;
    word_t   head_value;
    status_t status;
  } req_row_t;

  typedef struct packed {
    word_t   head_value;
    status_t status;
  } resp_t;

  logic clk = 1'b0;
  logic rst;

  mqsb_req_if req_ch ();
  mqsb_rsp_if rsp_ch ();

  multi_queue_shared_buffer #(
    .NUM_QUEUES  (NUM_QUEUES),
    .BUFFER_SLOTS(BUFFER_SLOTS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Shadow copy of the buffer: slot chains, queue pointers and the free stack
  word_t      slot_value [BUFFER_SLOTS];
  logic [4:0] slot_next  [BUFFER_SLOTS];
  logic [4:0] queue_head [NUM_QUEUES];
  logic [4:0] queue_tail [NUM_QUEUES];
  logic       queue_live [NUM_QUEUES];
  logic [4:0] free_top;

  resp_t due_responses [$];
  int    error_count   = 0;
  int    send_idle_pct = 13;
  int    rsp_stall_pct = 87;
  logic  hold_wanted   = 1'b0;

  always #1 clk = ~clk;

  task automatic clear_buffer_model();
    for (int i = 0; i < BUFFER_SLOTS; i++) begin
      slot_value[i] = '0;
      slot_next[i]  = 5'(i + 1);
    end
    for (int q = 0; q < NUM_QUEUES; q++) begin
      queue_head[q] = '0;
      queue_tail[q] = '0;
      queue_live[q] = 1'b0;
    end
    free_top = '0;
  endtask

  // Apply one request to the shadow buffer and return the response it yields
  function automatic resp_t serve_request(op_t op, qid_t qid, word_t value);
    resp_t      r;
    logic [4:0] s;
    r.head_value = '0;
    r.status     = ST_OK;
    case (op)
      OP_PUSH: begin
        if (free_top == SLOT_NONE) begin
          r.status = ST_OVERFLOW;
        end else begin
          s        = free_top;
          free_top = slot_next[s];
          if (queue_live[qid]) begin
            slot_next[queue_tail[qid]] = s;
          end else begin
            queue_head[qid] = s;
            queue_live[qid] = 1'b1;
          end
          queue_tail[qid] = s;
          slot_value[s]   = value;
          slot_next[s]    = SLOT_NONE;
        end
      end
      OP_POP: begin
        if (!queue_live[qid]) begin
          r.status = ST_UNDERFLOW;
        end else begin
          s = queue_head[qid];
          if (slot_next[s] != SLOT_NONE) queue_head[qid] = slot_next[s];
          else queue_live[qid] = 1'b0;
          slot_next[s] = free_top;
          free_top     = s;
        end
      end
      OP_READ: begin
        if (!queue_live[qid]) r.status = ST_UNDERFLOW;
        else r.head_value = slot_value[queue_head[qid]];
      end
      default: ;
    endcase
    return r;
  endfunction

  // Offer one word at the falling edge, hold it until taken, then log its response
  task automatic offer_word(req_row_t row);
    resp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.op         <= row.op;
    req_ch.queue_id   <= row.queue_id;
    req_ch.push_value <= row.push_value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    predicted = serve_request(row.op, row.queue_id, row.push_value);
    if (row.typed) due_responses.push_back(resp_t'{row.head_value, row.status});
    else due_responses.push_back(predicted);
    @(negedge clk);
  endtask

  // Random traffic whose push/pop mix swings so queues reach both full and empty
  task automatic offer_random_words(int count);
    req_row_t row;
    int       push_pct;
    int       focus_q;
    int       r;
    push_pct = 48;
    focus_q  = -1;
    for (int n = 0; n < count; n++) begin
      if (n % 48 == 0) begin
        case ($urandom_range(2))
          0:       push_pct = 25;
          1:       push_pct = 48;
          default: push_pct = 72;
        endcase
        focus_q = ($urandom_range(3) == 0) ? int'($urandom_range(NUM_QUEUES - 1)) : -1;
      end
      r = $urandom_range(99);
      if (r < 3) row.op = OP_UNUSED;
      else if (r < 3 + push_pct) row.op = OP_PUSH;
      else if (r < 3 + push_pct + (97 - push_pct) * 2 / 3) row.op = OP_POP;
      else row.op = OP_READ;
      row.queue_id = (focus_q >= 0) ? qid_t'(focus_q) : qid_t'($urandom_range(NUM_QUEUES - 1));
      case ($urandom_range(11))
        0:       row.push_value = word_t'(32'h8000_0000);
        1:       row.push_value = word_t'(32'h7fff_ffff);
        2:       row.push_value = '1;
        3:       row.push_value = '0;
        default: row.push_value = word_t'($urandom);
      endcase
      row.typed      = 1'b0;
      row.head_value = '0;
      row.status     = ST_OK;
      offer_word(row);
    end
  endtask

  // Drive response ready: random stalls, plus one long hold-off on request
  initial begin
    int   hold_left;
    logic hold_started;
    hold_left    = 0;
    hold_started = 1'b0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_wanted && !hold_started) begin
        hold_left    = LONG_HOLD_CYCLES;
        hold_started = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
    end
  end

  // Check each response word against the oldest expectation
  always @(posedge clk) begin
    resp_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (due_responses.size() == 0) begin
        $error("unexpected response: head_value %0d, status %0d",
               rsp_ch.head_value, rsp_ch.status);
        error_count++;
      end else begin
        want = due_responses.pop_front();
        if (rsp_ch.head_value !== want.head_value) begin
          $error("head_value: expected %0d, got %0d", want.head_value, rsp_ch.head_value);
          error_count++;
        end
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          error_count++;
        end
      end
    end
  end

  initial begin
    req_row_t directed [$];
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.op         = OP_PUSH;
    req_ch.queue_id   = '0;
    req_ch.push_value = '0;

    // Empty queues, ignored op, extreme values, then fill to overflow
    directed.push_back(req_row_t'{OP_READ, 2'd0, 32'sd0, 1'b1, 32'sd0, ST_UNDERFLOW});
    directed.push_back(req_row_t'{OP_POP, 2'd3, 32'sd0, 1'b1, 32'sd0, ST_UNDERFLOW});
    directed.push_back(req_row_t'{OP_UNUSED, 2'd1, -32'sd1, 1'b1, 32'sd0, ST_OK});
    directed.push_back(req_row_t'{OP_PUSH, 2'd0, word_t'(32'h8000_0000), 1'b1, 32'sd0, ST_OK});
    directed.push_back(req_row_t'{OP_PUSH, 2'd0, word_t'(32'h7fff_ffff), 1'b1, 32'sd0, ST_OK});
    directed.push_back(req_row_t'{OP_READ, 2'd0, 32'sd0, 1'b1, word_t'(32'h8000_0000), ST_OK});
    directed.push_back(req_row_t'{OP_POP, 2'd0, 32'sd0, 1'b1, 32'sd0, ST_OK});
    directed.push_back(req_row_t'{OP_READ, 2'd0, 32'sd0, 1'b1, word_t'(32'h7fff_ffff), ST_OK});
    for (int i = 0; i < BUFFER_SLOTS - 1; i++) begin
      directed.push_back(req_row_t'{OP_PUSH, qid_t'(i % NUM_QUEUES),
                                    word_t'(32'h0101_0101 * i), 1'b0, 32'sd0, ST_OK});
    end
    directed.push_back(req_row_t'{OP_PUSH, 2'd2, -32'sd1, 1'b1, 32'sd0, ST_OVERFLOW});
    directed.push_back(req_row_t'{OP_POP, 2'd1, 32'sd0, 1'b0, 32'sd0, ST_OK});

    clear_buffer_model();
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[i]) offer_word(directed[i]);

    // Sender busy, receiver mostly stalled
    offer_random_words(400);

    // Hold off the receiver long enough to back up the input, sender keeps going
    send_idle_pct = 0;
    hold_wanted   = 1'b1;
    offer_random_words(30);

    // Pause the sender until the buffer has drained its responses
    req_ch.valid <= 1'b0;
    wait (due_responses.size() == 0);
    @(negedge clk);

    // Sender mostly idle, receiver eager
    send_idle_pct = 87;
    rsp_stall_pct = 13;
    offer_random_words(400);

    // Full rate on both sides
    send_idle_pct = 0;
    rsp_stall_pct = 0;
    offer_random_words(420);

    req_ch.valid <= 1'b0;
    wait (due_responses.size() == 0);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
